@@ src/prime_modular_arith_unit_core_assert.svh @@
// Assertion macros shared by the modular arithmetic unit.
`ifndef PRIME_MODULAR_ARITH_UNIT_CORE_ASSERT_SVH
`define PRIME_MODULAR_ARITH_UNIT_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define PMAU_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define PMAU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PMAU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PMAU_ASSERT(lbl, clk, rst_n, prop)
`define PMAU_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PMAU_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ src/pmau_pkg.sv @@
package pmau_pkg;

  localparam int unsigned OpW   = 3;
  localparam int unsigned OpndW = 63;
  localparam int unsigned ResW  = 30;
  localparam int unsigned StepW = 5;

  localparam logic [63:0] PrimeWide = 64'd1000000007;
  localparam logic [ResW-1:0] Prime  = PrimeWide[ResW-1:0];
  localparam logic [ResW-1:0] Fermat = Prime - 30'd2;

  // Barrett factor floor(2^60 / P) and the fold constant 2^32 mod P.
  localparam logic [63:0] MuWide   = (64'd1 << 60) / PrimeWide;
  localparam logic [30:0] Mu       = MuWide[30:0];
  localparam logic [63:0] C32Wide  = (64'd1 << 32) % PrimeWide;
  localparam logic [ResW-1:0] Pow32Mod = C32Wide[ResW-1:0];

  localparam logic [31:0] PrimeX1 = PrimeWide[31:0];
  localparam logic [31:0] PrimeX2 = 32'(64'd2 * PrimeWide);
  localparam logic [31:0] PrimeX3 = 32'(64'd3 * PrimeWide);
  localparam logic [31:0] PrimeX4 = 32'(64'd4 * PrimeWide);

  typedef enum logic [OpW-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_POW = 3'd3,
    OP_INV = 3'd4,
    OP_DIV = 3'd5
  } opcode_e;

  typedef enum logic [2:0] {XS_A_HI, XS_B_HI, XS_A, XS_ACC, XS_SQ} x_sel_e;
  typedef enum logic [1:0] {YS_C32, YS_B, YS_SQ, YS_ACC} y_sel_e;
  typedef enum logic [1:0] {ZS_ZERO, ZS_A_LO, ZS_B_LO} z_sel_e;
  typedef enum logic [2:0] {DST_NONE, DST_A, DST_B, DST_ACC, DST_SQ, DST_RES} dst_e;
  typedef enum logic [2:0] {
    SRC_MM, SRC_ADD, SRC_SUB, SRC_ONE, SRC_ZERO, SRC_A, SRC_B, SRC_ACC
  } src_e;
  typedef enum logic [1:0] {EXP_HOLD, EXP_LOAD_FERMAT, EXP_SHIFT} exp_op_e;
  typedef enum logic [2:0] {
    BR_NEXT, BR_ALWAYS, BR_DISPATCH, BR_EXP_ZERO, BR_BIT_CLR, BR_EXP_LAST, BR_IS_DIV,
    BR_DONE
  } branch_e;

  typedef enum logic [1:0] {MM_IDLE, MM_MU, MM_QP, MM_FIX} mm_state_e;

  typedef logic [StepW-1:0] step_t;

  typedef struct packed {
    logic    mm_go;
    x_sel_e  x_sel;
    y_sel_e  y_sel;
    z_sel_e  z_sel;
    dst_e    dst;
    src_e    src;
    exp_op_e exp_op;
    branch_e branch;
    step_t   target;
  } ucode_t;

  typedef struct packed {
    logic           exp_zero;
    logic           exp_bit0;
    logic           exp_last;
    logic           out_free;
    logic [OpW-1:0] opcode;
  } useq_status_t;

  typedef struct packed {
    logic idle;
    logic done;
  } mm_stat_t;

  // Reduces any 32-bit value modulo P; at most four subtractions are needed.
  function automatic logic [ResW-1:0] red32(input logic [31:0] v);
    logic [31:0] r;
    if (v >= PrimeX4) begin
      r = v - PrimeX4;
    end else if (v >= PrimeX3) begin
      r = v - PrimeX3;
    end else if (v >= PrimeX2) begin
      r = v - PrimeX2;
    end else if (v >= PrimeX1) begin
      r = v - PrimeX1;
    end else begin
      r = v;
    end
    return r[ResW-1:0];
  endfunction

endpackage

@@ src/pmau_modmul.sv @@
`include "prime_modular_arith_unit_core_assert.svh"

module pmau_modmul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [pmau_pkg::ResW-1:0]   x_i,
  input  logic [pmau_pkg::ResW-1:0]   y_i,
  input  logic [pmau_pkg::ResW-1:0]   z_i,
  output pmau_pkg::mm_stat_t          stat_o,
  output logic [pmau_pkg::ResW-1:0]   result_o
);
  import pmau_pkg::*;

  mm_state_e   state_q, state_d;
  logic [30:0] mul_a, mul_b;
  logic [61:0] mul_p;
  logic [59:0] prod_q;
  logic [61:0] t_q;
  logic [31:0] u_q;
  logic [31:0] rem;

  // One shared multiplier: x*y+z first, then the two Barrett products.
  assign mul_p = {31'b0, mul_a} * {31'b0, mul_b};

  always_comb begin
    state_d = state_q;
    mul_a   = {1'b0, x_i};
    mul_b   = {1'b0, y_i};
    case (state_q)
      MM_IDLE: begin
        if (start_i) begin
          state_d = MM_MU;
        end
      end
      MM_MU: begin
        mul_a   = prod_q[59:29];
        mul_b   = Mu;
        state_d = MM_QP;
      end
      MM_QP: begin
        mul_a   = t_q[61:31];
        mul_b   = {1'b0, Prime};
        state_d = MM_FIX;
      end
      MM_FIX: begin
        state_d = MM_IDLE;
      end
      default: begin
        state_d = MM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == MM_IDLE && start_i) begin
      prod_q <= mul_p[59:0] + {30'b0, z_i};
    end
    if (state_q == MM_MU) begin
      t_q <= mul_p;
    end
    if (state_q == MM_QP) begin
      u_q <= mul_p[31:0];
    end
  end

  // The true remainder is below 3P, so the low 32 bits carry it exactly.
  assign rem         = prod_q[31:0] - u_q;
  assign result_o    = red32(rem);
  assign stat_o.idle = (state_q == MM_IDLE);
  assign stat_o.done = (state_q == MM_FIX);

  `PMAU_ASSERT_IMP(a_mm_start_idle, clk_i, rst_ni, start_i, state_q == MM_IDLE)
  `PMAU_ASSERT_IMP(a_mm_barrett_bound, clk_i, rst_ni, state_q == MM_FIX, rem < PrimeX3)

endmodule

@@ src/pmau_useq.sv @@
`include "prime_modular_arith_unit_core_assert.svh"

module pmau_useq (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  pmau_pkg::useq_status_t  status_i,
  input  pmau_pkg::mm_stat_t      mm_stat_i,
  output pmau_pkg::ucode_t        cw_o,
  output logic                    fire_o,
  output logic                    busy_o,
  output logic                    mm_start_o
);
  import pmau_pkg::*;

  localparam step_t StepRedA   = 5'd0;
  localparam step_t StepRedB   = 5'd1;
  localparam step_t StepAdd    = 5'd2;
  localparam step_t StepSub    = 5'd3;
  localparam step_t StepMul    = 5'd4;
  localparam step_t StepNone   = 5'd5;
  localparam step_t StepPow    = 5'd6;
  localparam step_t StepInv    = 5'd7;
  localparam step_t StepAccOne = 5'd8;
  localparam step_t StepLoop   = 5'd9;
  localparam step_t StepBit    = 5'd10;
  localparam step_t StepAccMul = 5'd11;
  localparam step_t StepShift  = 5'd12;
  localparam step_t StepSquare = 5'd13;
  localparam step_t StepEnd    = 5'd14;
  localparam step_t StepRes    = 5'd15;
  localparam step_t StepDiv    = 5'd16;
  localparam step_t StepLast   = StepDiv;

  function automatic ucode_t uc(input logic go, input x_sel_e xs, input y_sel_e ys,
                                input z_sel_e zs, input dst_e dst, input src_e src,
                                input exp_op_e eop, input branch_e br, input step_t tgt);
    ucode_t w;
    w.mm_go  = go;
    w.x_sel  = xs;
    w.y_sel  = ys;
    w.z_sel  = zs;
    w.dst    = dst;
    w.src    = src;
    w.exp_op = eop;
    w.branch = br;
    w.target = tgt;
    return w;
  endfunction

  function automatic ucode_t rom(input step_t pc);
    case (pc)
      StepRedA:   return uc(1'b1, XS_A_HI, YS_C32, ZS_A_LO, DST_A, SRC_MM, EXP_HOLD,
                            BR_NEXT, StepRedA);
      StepRedB:   return uc(1'b1, XS_B_HI, YS_C32, ZS_B_LO, DST_B, SRC_MM, EXP_HOLD,
                            BR_DISPATCH, StepRedA);
      StepAdd:    return uc(1'b0, XS_A, YS_B, ZS_ZERO, DST_RES, SRC_ADD, EXP_HOLD,
                            BR_DONE, StepRedA);
      StepSub:    return uc(1'b0, XS_A, YS_B, ZS_ZERO, DST_RES, SRC_SUB, EXP_HOLD,
                            BR_DONE, StepRedA);
      StepMul:    return uc(1'b1, XS_A, YS_B, ZS_ZERO, DST_RES, SRC_MM, EXP_HOLD,
                            BR_DONE, StepRedA);
      StepNone:   return uc(1'b0, XS_A, YS_B, ZS_ZERO, DST_RES, SRC_ZERO, EXP_HOLD,
                            BR_DONE, StepRedA);
      StepPow:    return uc(1'b0, XS_A, YS_B, ZS_ZERO, DST_SQ, SRC_A, EXP_HOLD,
                            BR_ALWAYS, StepAccOne);
      StepInv:    return uc(1'b0, XS_A, YS_B, ZS_ZERO, DST_SQ, SRC_B, EXP_LOAD_FERMAT,
                            BR_NEXT, StepRedA);
      StepAccOne: return uc(1'b0, XS_A, YS_B, ZS_ZERO, DST_ACC, SRC_ONE, EXP_HOLD,
                            BR_NEXT, StepRedA);
      StepLoop:   return uc(1'b0, XS_A, YS_B, ZS_ZERO, DST_NONE, SRC_ZERO, EXP_HOLD,
                            BR_EXP_ZERO, StepEnd);
      StepBit:    return uc(1'b0, XS_A, YS_B, ZS_ZERO, DST_NONE, SRC_ZERO, EXP_HOLD,
                            BR_BIT_CLR, StepShift);
      StepAccMul: return uc(1'b1, XS_ACC, YS_SQ, ZS_ZERO, DST_ACC, SRC_MM, EXP_HOLD,
                            BR_NEXT, StepRedA);
      StepShift:  return uc(1'b0, XS_A, YS_B, ZS_ZERO, DST_NONE, SRC_ZERO, EXP_SHIFT,
                            BR_EXP_LAST, StepEnd);
      StepSquare: return uc(1'b1, XS_SQ, YS_SQ, ZS_ZERO, DST_SQ, SRC_MM, EXP_HOLD,
                            BR_ALWAYS, StepBit);
      StepEnd:    return uc(1'b0, XS_A, YS_B, ZS_ZERO, DST_NONE, SRC_ZERO, EXP_HOLD,
                            BR_IS_DIV, StepDiv);
      StepRes:    return uc(1'b0, XS_A, YS_B, ZS_ZERO, DST_RES, SRC_ACC, EXP_HOLD,
                            BR_DONE, StepRedA);
      StepDiv:    return uc(1'b1, XS_A, YS_ACC, ZS_ZERO, DST_RES, SRC_MM, EXP_HOLD,
                            BR_DONE, StepRedA);
      default:    return uc(1'b0, XS_A, YS_B, ZS_ZERO, DST_RES, SRC_ZERO, EXP_HOLD,
                            BR_DONE, StepRedA);
    endcase
  endfunction

  function automatic step_t entry(input logic [OpW-1:0] op);
    case (op)
      OP_ADD:  return StepAdd;
      OP_SUB:  return StepSub;
      OP_MUL:  return StepMul;
      OP_POW:  return StepPow;
      OP_INV:  return StepInv;
      OP_DIV:  return StepInv;
      default: return StepNone;
    endcase
  endfunction

  step_t  pc_q, pc_d;
  logic   busy_q, busy_d;
  ucode_t cw;
  step_t  pc_inc;

  assign cw     = rom(pc_q);
  assign pc_inc = pc_q + 5'd1;

  // A step retires when its multiply is finished and, for the last step,
  // when the output register can take the result.
  assign fire_o = busy_q && (!cw.mm_go || mm_stat_i.done) &&
                  ((cw.branch != BR_DONE) || status_i.out_free);
  assign mm_start_o = busy_q && cw.mm_go && mm_stat_i.idle;
  assign cw_o       = cw;
  assign busy_o     = busy_q;

  always_comb begin
    pc_d   = pc_q;
    busy_d = busy_q;
    if (start_i) begin
      pc_d   = StepRedA;
      busy_d = 1'b1;
    end else if (fire_o) begin
      case (cw.branch)
        BR_NEXT:     pc_d = pc_inc;
        BR_ALWAYS:   pc_d = cw.target;
        BR_DISPATCH: pc_d = entry(status_i.opcode);
        BR_EXP_ZERO: pc_d = status_i.exp_zero ? cw.target : pc_inc;
        BR_BIT_CLR:  pc_d = status_i.exp_bit0 ? pc_inc : cw.target;
        BR_EXP_LAST: pc_d = status_i.exp_last ? cw.target : pc_inc;
        BR_IS_DIV:   pc_d = (status_i.opcode == OP_DIV) ? cw.target : pc_inc;
        BR_DONE:     busy_d = 1'b0;
        default:     pc_d = pc_inc;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= StepRedA;
      busy_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      busy_q <= busy_d;
    end
  end

  `PMAU_ASSERT_IMP(a_seq_start_idle, clk_i, rst_ni, start_i, !busy_q)
  `PMAU_ASSERT_IMP(a_seq_pc_range, clk_i, rst_ni, busy_q, pc_q <= StepLast)
  `PMAU_ASSERT_NXT(a_seq_done_idle, clk_i, rst_ni, fire_o && (cw.branch == BR_DONE), !busy_q)

endmodule

@@ src/prime_modular_arith_unit_core.sv @@
// Channel  Handshake                   Payload
// in       in_valid_i / in_stall_o     opcode_i, operand_a_i, operand_b_i
// out      out_valid_o / out_stall_i   result_o
//
// One request at a time runs a microcode program; each modular multiply runs on the
// one shared 31x31 Barrett multiplier. Power squares and multiplies over the exponent
// from its low bit up; inverse raises b to P-2 by the same loop, and divide then
// multiplies a by that inverse.
// Reset is asynchronous and clears only the control state and the output valid.
// While a result waits on a stalled output the last step waits, and so does the input.
`include "prime_modular_arith_unit_core_assert.svh"

module prime_modular_arith_unit_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [pmau_pkg::OpW-1:0]     opcode_i,
  input  logic [pmau_pkg::OpndW-1:0]   operand_a_i,
  input  logic [pmau_pkg::OpndW-1:0]   operand_b_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [pmau_pkg::ResW-1:0]    result_o
);
  import pmau_pkg::*;

  logic              in_accept;
  logic              busy;
  logic              fire;
  logic              mm_start;
  ucode_t            cw;
  useq_status_t      status;
  mm_stat_t          mm_stat;

  logic [OpW-1:0]    op_q;
  logic [ResW-1:0]   a_hi_q, a_lo_q, b_hi_q, b_lo_q;
  logic [ResW-1:0]   a_q, b_q, acc_q, sq_q;
  logic [OpndW-1:0]  exp_q;
  logic              out_valid_q;
  logic [ResW-1:0]   result_q;

  logic [ResW-1:0]   mm_x, mm_y, mm_z, mm_res;
  logic [ResW-1:0]   wr_val;
  logic [31:0]       add_sum, sub_sum;

  assign in_accept  = in_valid_i && !busy;
  assign in_stall_o = busy;

  assign status.exp_zero = (exp_q == '0);
  assign status.exp_bit0 = exp_q[0];
  assign status.exp_last = (exp_q[OpndW-1:1] == '0);
  assign status.out_free = !out_valid_q || !out_stall_i;
  assign status.opcode   = op_q;

  pmau_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_accept),
    .status_i   (status),
    .mm_stat_i  (mm_stat),
    .cw_o       (cw),
    .fire_o     (fire),
    .busy_o     (busy),
    .mm_start_o (mm_start)
  );

  pmau_modmul u_modmul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mm_start),
    .x_i      (mm_x),
    .y_i      (mm_y),
    .z_i      (mm_z),
    .stat_o   (mm_stat),
    .result_o (mm_res)
  );

  always_comb begin
    case (cw.x_sel)
      XS_A_HI: mm_x = a_hi_q;
      XS_B_HI: mm_x = b_hi_q;
      XS_A:    mm_x = a_q;
      XS_ACC:  mm_x = acc_q;
      XS_SQ:   mm_x = sq_q;
      default: mm_x = a_q;
    endcase
    case (cw.y_sel)
      YS_C32:  mm_y = Pow32Mod;
      YS_B:    mm_y = b_q;
      YS_SQ:   mm_y = sq_q;
      YS_ACC:  mm_y = acc_q;
      default: mm_y = b_q;
    endcase
    case (cw.z_sel)
      ZS_ZERO: mm_z = '0;
      ZS_A_LO: mm_z = a_lo_q;
      ZS_B_LO: mm_z = b_lo_q;
      default: mm_z = '0;
    endcase
  end

  assign add_sum = {2'b0, a_q} + {2'b0, b_q};
  assign sub_sum = {2'b0, a_q} + {2'b0, Prime} - {2'b0, b_q};

  always_comb begin
    case (cw.src)
      SRC_MM:   wr_val = mm_res;
      SRC_ADD:  wr_val = red32(add_sum);
      SRC_SUB:  wr_val = red32(sub_sum);
      SRC_ONE:  wr_val = 30'd1;
      SRC_ZERO: wr_val = '0;
      SRC_A:    wr_val = a_q;
      SRC_B:    wr_val = b_q;
      SRC_ACC:  wr_val = acc_q;
      default:  wr_val = '0;
    endcase
  end

  // A 63-bit operand is folded as hi * (2^32 mod P) + lo with both halves
  // pre-reduced here, so the multiplier input never exceeds 2^60.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q   <= opcode_i;
      a_hi_q <= red32({1'b0, operand_a_i[OpndW-1:32]});
      a_lo_q <= red32(operand_a_i[31:0]);
      b_hi_q <= red32({1'b0, operand_b_i[OpndW-1:32]});
      b_lo_q <= red32(operand_b_i[31:0]);
      exp_q  <= operand_b_i;
    end else if (fire) begin
      case (cw.exp_op)
        EXP_LOAD_FERMAT: exp_q <= {{(OpndW-ResW){1'b0}}, Fermat};
        EXP_SHIFT:       exp_q <= {1'b0, exp_q[OpndW-1:1]};
        default:         exp_q <= exp_q;
      endcase
    end
    if (fire) begin
      case (cw.dst)
        DST_A:   a_q      <= wr_val;
        DST_B:   b_q      <= wr_val;
        DST_ACC: acc_q    <= wr_val;
        DST_SQ:  sq_q     <= wr_val;
        DST_RES: result_q <= wr_val;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= (out_valid_q && out_stall_i) || (fire && (cw.dst == DST_RES));
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  `PMAU_ASSERT_IMP(a_top_result_range, clk_i, rst_ni, out_valid_o, result_o < Prime)

endmodule
